// ----- design/lmsp_pkg.sv -----
// Shared types and constants for the LED matrix scan with pan block.
`default_nettype none
package lmsp_pkg;

    localparam int unsigned CfgDataW  = 64;
    localparam int unsigned CfgAddrW  = 6;
    localparam int unsigned RegIdxW   = 3;

    // Register indexes (byte address = 8 * index)
    localparam logic [RegIdxW-1:0] REG_FRAME_ZERO   = 3'd0;
    localparam logic [RegIdxW-1:0] REG_FRAME_ONE    = 3'd1;
    localparam logic [RegIdxW-1:0] REG_FRAME_TWO    = 3'd2;
    localparam logic [RegIdxW-1:0] REG_FRAME_PERIOD = 3'd3;
    localparam logic [RegIdxW-1:0] REG_REPEAT_LIMIT = 3'd4;

    localparam logic [15:0] FRAME_PERIOD_RST = 16'd2000;
    localparam logic [7:0]  REPEAT_LIMIT_RST = 8'd25;

    // Opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    // Key codes, active low
    localparam logic [7:0] KEY_UP      = 8'hFE;
    localparam logic [7:0] KEY_DOWN    = 8'hFD;
    localparam logic [7:0] KEY_RIGHT   = 8'hF7;
    localparam logic [7:0] KEY_LEFT    = 8'hFB;
    localparam logic [7:0] KEY_RELEASE = 8'hFF;

    localparam logic [1:0]        FRAME_COUNT = 2'd3;
    localparam logic signed [3:0] MAX_PAN     = 4'sd7;

    typedef struct packed {
        logic [63:0] frame_zero;
        logic [63:0] frame_one;
        logic [63:0] frame_two;
        logic [15:0] frame_period;
        logic [7:0]  repeat_limit;
    } t_cfg;

    typedef struct packed {
        logic       opcode;
        logic [7:0] key_code;
    } t_item;

    typedef struct packed {
        logic [7:0] column_select;
        logic [7:0] row_drive_n;
    } t_result;

endpackage
`default_nettype wire

// ----- design/led_matrix_scan_with_pan_top.sv -----
// Top level: item handshake, input/result registers, config port and engine.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+----------------------------------
//  input   | i_in_valid / o_in_stall     | i_opcode, i_key_code
//  result  | o_out_valid / i_out_stall   | o_column_select, o_row_drive_n
//  config  | psel/penable/pwrite, pready | paddr, pwdata, prdata (64 bits)
//
// One beat per cycle sustained while the result side does not stall; a scan
// tick's result passes through the input register, then the result register.
// Key samples give no result and never wait on the result side. A stalled
// result holds the stage behind it only when that stage holds a tick. Reset is
// synchronous: all scan, pan and counter state clears, period and repeat
// limit return to defaults.
`default_nettype none
module led_matrix_scan_with_pan_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_opcode,
    input  wire logic [7:0]                    i_key_code,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [7:0]                    o_column_select,
    output logic      [7:0]                    o_row_drive_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lmsp_pkg::CfgAddrW-1:0] paddr,
    input  wire logic [lmsp_pkg::CfgDataW-1:0] pwdata,
    output logic      [lmsp_pkg::CfgDataW-1:0] prdata,
    output logic                               pready
);

    lmsp_pkg::t_cfg    cfg;
    lmsp_pkg::t_item   r_item;
    logic              r_in_valid;
    lmsp_pkg::t_result r_result;
    logic              r_out_valid;
    lmsp_pkg::t_result result;
    logic              advance;
    logic              in_take;

    lmsp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lmsp_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (advance),
        .i_item   (r_item),
        .o_result (result)
    );

    // Retire the held item when it makes no result or the result slot frees
    assign advance = r_in_valid &
                     ((r_item.opcode == lmsp_pkg::OP_KEY) | ~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_in_valid & ~advance;
    assign in_take    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.opcode   <= i_opcode;
            r_item.key_code <= i_key_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_item.opcode == lmsp_pkg::OP_TICK) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_item.opcode == lmsp_pkg::OP_TICK) begin
            r_result <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_column_select = r_result.column_select;
    assign o_row_drive_n   = r_result.row_drive_n;

endmodule
`default_nettype wire

// ----- design/lmsp_regs.sv -----
// APB configuration register file for the LED matrix scan block.
`default_nettype none
module lmsp_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lmsp_pkg::CfgAddrW-1:0] paddr,
    input  wire logic [lmsp_pkg::CfgDataW-1:0] pwdata,
    output logic      [lmsp_pkg::CfgDataW-1:0] prdata,
    output logic                               pready,
    output lmsp_pkg::t_cfg                     o_cfg
);

    lmsp_pkg::t_cfg                  r_cfg;
    logic [lmsp_pkg::RegIdxW-1:0]    idx;
    logic                            wr_en;

    assign idx    = paddr[lmsp_pkg::CfgAddrW-1:lmsp_pkg::CfgAddrW-lmsp_pkg::RegIdxW];
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_zero   <= '0;
            r_cfg.frame_one    <= '0;
            r_cfg.frame_two    <= '0;
            r_cfg.frame_period <= lmsp_pkg::FRAME_PERIOD_RST;
            r_cfg.repeat_limit <= lmsp_pkg::REPEAT_LIMIT_RST;
        end else if (wr_en) begin
            unique case (idx)
                lmsp_pkg::REG_FRAME_ZERO:   r_cfg.frame_zero   <= pwdata;
                lmsp_pkg::REG_FRAME_ONE:    r_cfg.frame_one    <= pwdata;
                lmsp_pkg::REG_FRAME_TWO:    r_cfg.frame_two    <= pwdata;
                lmsp_pkg::REG_FRAME_PERIOD: r_cfg.frame_period <= pwdata[15:0];
                lmsp_pkg::REG_REPEAT_LIMIT: r_cfg.repeat_limit <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            lmsp_pkg::REG_FRAME_ZERO:   prdata = r_cfg.frame_zero;
            lmsp_pkg::REG_FRAME_ONE:    prdata = r_cfg.frame_one;
            lmsp_pkg::REG_FRAME_TWO:    prdata = r_cfg.frame_two;
            lmsp_pkg::REG_FRAME_PERIOD: prdata = {48'd0, r_cfg.frame_period};
            lmsp_pkg::REG_REPEAT_LIMIT: prdata = {56'd0, r_cfg.repeat_limit};
            default:                    prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/lmsp_engine.sv -----
// Scan/pan state and the single-pass result logic for one item.
`default_nettype none
module lmsp_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lmsp_pkg::t_cfg  i_cfg,
    input  wire logic            i_step,
    input  wire lmsp_pkg::t_item i_item,
    output lmsp_pkg::t_result    o_result
);

    logic [15:0]       r_tick_count, n_tick_count;
    logic [1:0]        r_frame_index, n_frame_index;
    logic [2:0]        r_scan_column, n_scan_column;
    logic signed [3:0] r_pan_x, n_pan_x;
    logic signed [3:0] r_pan_y, n_pan_y;
    logic [7:0]        r_hold_count, n_hold_count;

    logic [15:0]       tick_inc;
    logic [1:0]        frame_inc;
    logic [2:0]        col_next;
    logic signed [4:0] pos;
    logic [63:0]       frame;
    logic [7:0]        col_byte;
    logic [7:0]        dat;
    logic [3:0]        neg_y;
    logic [7:0]        hold_inc;

    // Tick path: counter, frame, column and shifted byte
    always_comb begin
        tick_inc  = r_tick_count + 16'd1;
        frame_inc = r_frame_index + 2'd1;
        n_tick_count  = tick_inc;
        n_frame_index = r_frame_index;
        if (tick_inc >= i_cfg.frame_period) begin
            n_tick_count  = '0;
            n_frame_index = (frame_inc >= lmsp_pkg::FRAME_COUNT) ? 2'd0 : frame_inc;
        end
        col_next      = r_scan_column + 3'd1;
        n_scan_column = col_next;

        case (n_frame_index)
            2'd1:    frame = i_cfg.frame_one;
            2'd2:    frame = i_cfg.frame_two;
            default: frame = i_cfg.frame_zero;
        endcase

        pos      = $signed({2'b00, col_next}) + 5'(r_pan_x);
        col_byte = 8'(frame >> {pos[2:0], 3'b000});
        // Blank positions left of column 0 or right of column 7
        dat      = (pos[4:3] == 2'b00) ? col_byte : 8'd0;
        neg_y    = 4'(-r_pan_y);
        if (r_pan_y > 4'sd0) begin
            dat = dat >> r_pan_y[2:0];
        end else if (r_pan_y < 4'sd0) begin
            dat = dat << neg_y[2:0];
        end

        o_result.column_select = 8'd1 << col_next;
        o_result.row_drive_n   = ~dat;
    end

    // Key path: repeat counter and saturating pan steps
    always_comb begin
        hold_inc     = r_hold_count + 8'd1;
        n_pan_x      = r_pan_x;
        n_pan_y      = r_pan_y;
        n_hold_count = hold_inc;
        if (i_item.key_code == lmsp_pkg::KEY_RELEASE) begin
            n_hold_count = '0;
        end else if (hold_inc > i_cfg.repeat_limit) begin
            n_hold_count = '0;
            case (i_item.key_code)
                lmsp_pkg::KEY_UP:
                    if (r_pan_y < lmsp_pkg::MAX_PAN) n_pan_y = r_pan_y + 4'sd1;
                lmsp_pkg::KEY_DOWN:
                    if (r_pan_y > -lmsp_pkg::MAX_PAN) n_pan_y = r_pan_y - 4'sd1;
                lmsp_pkg::KEY_RIGHT:
                    if (r_pan_x < lmsp_pkg::MAX_PAN) n_pan_x = r_pan_x + 4'sd1;
                lmsp_pkg::KEY_LEFT:
                    if (r_pan_x > -lmsp_pkg::MAX_PAN) n_pan_x = r_pan_x - 4'sd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count  <= '0;
            r_frame_index <= '0;
            r_scan_column <= '0;
            r_pan_x       <= '0;
            r_pan_y       <= '0;
            r_hold_count  <= '0;
        end else if (i_step) begin
            if (i_item.opcode == lmsp_pkg::OP_TICK) begin
                r_tick_count  <= n_tick_count;
                r_frame_index <= n_frame_index;
                r_scan_column <= n_scan_column;
            end else begin
                r_pan_x      <= n_pan_x;
                r_pan_y      <= n_pan_y;
                r_hold_count <= n_hold_count;
            end
        end
    end

endmodule
`default_nettype wire
